// File: rtl/slfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync and length frame parser package
// Shared constants and types for the byte-stream frame parser.
// ----------------------------------------------------------------------------
package slfp_pkg;

	// Sync pair and header size
	localparam logic [7:0] SYNC_FIRST   = 8'h50;
	localparam logic [7:0] SYNC_SECOND  = 8'h53;
	localparam logic [3:0] HEADER_BYTES = 4'd8;
	// Header bytes two and three carry the id, four to seven the length
	localparam logic [3:0] LENGTH_START = 4'd4;

	// Field widths
	localparam int unsigned ID_W    = 16;
	localparam int unsigned LEN_W   = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 16;
	localparam int unsigned MAXLEN_W = 16;

	// Result item on the output stream
	localparam int unsigned OUT_DATA_W = ID_W + LEN_W + BYTE_W + INDEX_W;

	// Reset value of the maximum body length register
	localparam logic [MAXLEN_W-1:0] MAX_BODY_LENGTH_RESET = 16'd1024;

	// Kind of result item
	typedef enum logic [1:0] {
		KIND_BODY_BYTE = 2'd0,
		KIND_EMPTY     = 2'd1,
		KIND_TOO_LARGE = 2'd2
	} event_kind_t;

endpackage

// File: rtl/sync_length_frame_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync and length frame parser core
// Hunts for the sync pair, gathers id and length, streams body bytes out.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  ---------+-----------+----------------------------------------------------
//  s_*      | in        | tdata: rx_byte; tuser: restart
//  m_*      | out       | tdata: message_id, body_length, data_byte,
//           |           |        byte_index; tuser: event_kind; tlast: last
//  cfg_*    | in        | max_body_length, written when cfg_wr_en is high
//
//  One byte is taken every cycle unless the output stalls; a result passes
//  through the input register and then the result register.
//  arst_n clears the parser state, both valid flags and sets the maximum
//  body length to 1024.
//  A stalled result holds in the result register; the input register moves
//  on whenever the result register is free or being emptied.
// ----------------------------------------------------------------------------
module sync_length_frame_parser_core
	import slfp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration
	input  logic                  cfg_wr_en,
	input  logic [MAXLEN_W-1:0]   cfg_wr_data,   // max_body_length
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,       // [7:0] rx_byte
	input  logic [0:0]            s_tuser,       // [0] restart
	// Output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,       // [15:0] message_id,
	                                             // [47:16] body_length,
	                                             // [55:48] data_byte,
	                                             // [71:56] byte_index
	output logic [1:0]            m_tuser,       // [1:0] event_kind
	output logic                  m_tlast        // last
);

	// Configuration register
	logic [MAXLEN_W-1:0] max_len_q;

	// Input register stage
	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              restart_s1;

	// Parser state
	logic [3:0]         pos_q;
	logic               in_body_q;
	logic [ID_W-1:0]    id_q;
	logic [LEN_W-1:0]   len_q;
	logic [INDEX_W-1:0] count_q;

	// Next state
	logic [3:0]         pos_d;
	logic               in_body_d;
	logic [ID_W-1:0]    id_d;
	logic [LEN_W-1:0]   len_d;
	logic [INDEX_W-1:0] count_d;

	// Result of the item in the input stage
	logic               res_valid;
	event_kind_t        res_kind;
	logic [ID_W-1:0]    res_id;
	logic [LEN_W-1:0]   res_len;
	logic [BYTE_W-1:0]  res_byte;
	logic [INDEX_W-1:0] res_index;
	logic               res_last;

	// Result register stage
	logic               vld_s2;
	event_kind_t        kind_s2;
	logic [ID_W-1:0]    id_s2;
	logic [LEN_W-1:0]   len_s2;
	logic [BYTE_W-1:0]  byte_s2;
	logic [INDEX_W-1:0] index_s2;
	logic               last_s2;

	logic               adv_s1;
	logic [3:0]         pos_inc;
	logic [LEN_W-1:0]   index_next;

	// Handshake: the input stage moves when the result register is free
	assign adv_s1   = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || adv_s1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_BODY_LENGTH_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1    <= s_tdata;
			restart_s1 <= s_tuser[0];
		end
	end

	// Parser step for the byte in the input stage
	always_comb begin
		pos_d      = pos_q;
		in_body_d  = in_body_q;
		id_d       = id_q;
		len_d      = len_q;
		count_d    = count_q;
		res_valid  = 1'b0;
		res_kind   = KIND_BODY_BYTE;
		res_id     = id_q;
		res_len    = len_q;
		res_byte   = '0;
		res_index  = '0;
		res_last   = 1'b1;
		pos_inc    = pos_q + 4'd1;
		index_next = {{(LEN_W-INDEX_W){1'b0}}, count_q} + {{(LEN_W-1){1'b0}}, 1'b1};

		if (restart_s1) begin
			pos_d     = '0;
			in_body_d = 1'b0;
			id_d      = '0;
			len_d     = '0;
			count_d   = '0;
		end else if (in_body_q) begin
			// Stream one body byte; the final one ends the frame
			res_valid = 1'b1;
			res_byte  = byte_s1;
			res_index = count_q;
			res_last  = (index_next >= len_q);
			count_d   = index_next[INDEX_W-1:0];
			if (res_last) begin
				pos_d     = '0;
				in_body_d = 1'b0;
				id_d      = '0;
				len_d     = '0;
				count_d   = '0;
			end
		end else begin
			case (pos_q) inside
				4'd0: begin
					if (byte_s1 == SYNC_FIRST) begin
						pos_d = 4'd1;
					end
				end
				4'd1: begin
					if (byte_s1 == SYNC_SECOND) begin
						pos_d = 4'd2;
					end else if (byte_s1 == SYNC_FIRST) begin
						pos_d = 4'd1;
					end else begin
						pos_d = 4'd0;
					end
				end
				default: begin
					// Shift header bytes in, most significant first
					if (pos_q < LENGTH_START) begin
						id_d = {id_q[ID_W-BYTE_W-1:0], byte_s1};
					end else begin
						len_d = {len_q[LEN_W-BYTE_W-1:0], byte_s1};
					end
					pos_d    = pos_inc;
					res_id   = id_d;
					res_len  = len_d;
					if (pos_inc == HEADER_BYTES) begin
						count_d = '0;
						if (len_d > {{(LEN_W-MAXLEN_W){1'b0}}, max_len_q}) begin
							res_valid = 1'b1;
							res_kind  = KIND_TOO_LARGE;
						end else if (len_d == '0) begin
							res_valid = 1'b1;
							res_kind  = KIND_EMPTY;
						end else begin
							in_body_d = 1'b1;
						end
						if (res_valid) begin
							pos_d     = '0;
							in_body_d = 1'b0;
							id_d      = '0;
							len_d     = '0;
						end
					end
				end
			endcase
		end
	end

	// Parser state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			in_body_q <= 1'b0;
			id_q      <= '0;
			len_q     <= '0;
			count_q   <= '0;
		end else if (vld_s1 && adv_s1) begin
			pos_q     <= pos_d;
			in_body_q <= in_body_d;
			id_q      <= id_d;
			len_q     <= len_d;
			count_q   <= count_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= vld_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && vld_s1 && res_valid) begin
			kind_s2  <= res_kind;
			id_s2    <= res_id;
			len_s2   <= res_len;
			byte_s2  <= res_byte;
			index_s2 <= res_index;
			last_s2  <= res_last;
		end
	end

	// Output stream
	assign m_tvalid = vld_s2;
	assign m_tdata  = {index_s2, byte_s2, len_s2, id_s2};
	assign m_tuser  = kind_s2;
	assign m_tlast  = last_s2;

	// While streaming a body, the whole header has been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> pos_q == HEADER_BYTES)
		else $error("body streaming without a complete header");

	// The body counter never reaches the announced length while in the body
	assert property (@(posedge clk) disable iff (!arst_n)
		in_body_q |-> {{(LEN_W-INDEX_W){1'b0}}, count_q} < len_q)
		else $error("body counter ran past the body length");

	// Empty and oversize results are single-item frames with no payload byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && kind_s2 != KIND_BODY_BYTE) |-> (last_s2 && byte_s2 == '0 && index_s2 == '0))
		else $error("non-byte result with byte fields set");

	// Outside the body the header position stays below the header size
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_body_q |-> pos_q < HEADER_BYTES)
		else $error("header position out of range while hunting");

endmodule
